### rtl/core/bsa_pkg.sv
// Shared types, constants and helper functions of the bitmap slot allocator.
// No dependencies; every other file of the block imports this package.

package bsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int WORD_BITS  = 8;
    localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W       = $clog2(WORD_COUNT);
    localparam int WC_W       = $clog2(WORD_COUNT + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;

    localparam logic [WORD_BITS-1:0] FULL_WORD = 8'hff;
    localparam logic [WORD_BITS:0]   ONE_PAST  = 9'h100;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TEST    = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_USED    = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    // One access cycle of the bitmap memory
    typedef struct packed {
        logic            rd_en;
        logic [WA_W-1:0] rd_addr;
        logic            wr_en;
        logic [WA_W-1:0] wr_addr;
        t_word           wr_data;
    } t_ram_req;

    // Slot count write, already saturated
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] count;
    } t_cfg_wr;

    // Finished result handed to the output register
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [IDX_W-1:0] slot;
        logic             was_used;
        logic [CNT_W-1:0] free;
    } t_result;

    // Bits of word w that hold slots below n
    function automatic t_word valid_bits(input logic [WA_W-1:0] w, input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0]   base;
        logic [CNT_W-1:0]   rest;
        logic [WORD_BITS:0] one_hot;
        t_word              res;
        base    = CNT_W'({w, {BIT_W{1'b0}}});
        rest    = n - base;
        one_hot = (ONE_PAST >> WORD_BITS) << rest[BIT_W-1:0];
        if (base >= n) begin
            res = '0;
        end else if (rest >= CNT_W'(WORD_BITS)) begin
            res = FULL_WORD;
        end else begin
            res = t_word'(one_hot - (WORD_BITS+1)'(1));
        end
        return res;
    endfunction

    // Position of the lowest set bit
    function automatic logic [BIT_W-1:0] lowest_bit(input t_word v);
        logic [BIT_W-1:0] res;
        res = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = BIT_W'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [BIT_W:0] pop_count(input t_word v);
        logic [BIT_W:0] res;
        res = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            res = res + (BIT_W+1)'(v[i]);
        end
        return res;
    endfunction

    // Number of words that hold slots below n
    function automatic logic [WC_W-1:0] words_in_use(input logic [CNT_W-1:0] n);
        logic [CNT_W:0] tmp;
        tmp = {1'b0, n} + (CNT_W+1)'(WORD_BITS - 1);
        return WC_W'(tmp >> BIT_W);
    endfunction

endpackage

### rtl/core/bsa_if.sv
// Valid/ready channel interfaces of the bitmap slot allocator.
// Depends on bsa_pkg for the field widths.

interface bsa_in_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] slot_index;

    modport source (output valid, output operation, output slot_index, input ready);
    modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface bsa_out_if import bsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot_out;
    logic             slot_was_used;
    logic [CNT_W-1:0] free_slots;

    modport source (output valid, output status, output slot_out, output slot_was_used,
                    output free_slots, input ready);
    modport sink   (input valid, input status, input slot_out, input slot_was_used,
                    input free_slots, output ready);
endinterface

### rtl/core/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: slot count register, output register
// and the sequencer with its bitmap memory. Depends on bsa_pkg, bsa_if,
// bsa_ram and bsa_ctrl.

// The block keeps a bitmap of up to 1024 slots in a 128 x 8-bit memory and
// answers one transaction at a time. Claim, release and test read the addressed
// memory word; claim (when the slot is free) and release then modify it and
// write it back. Allocate scans next-fit from the remembered word, one memory
// word per cycle while the output register can take a result. The scan stops at
// the first word with a free slot, or reports no free slot once every word in
// use has been examined. After reset a clearing pass sweeps the memory once and
// clears every slot; after each slot count write a pass masks slots at or past
// the count and recounts the used ones. No transaction is accepted during a
// pass. A finished result sits in an output register, so the next transaction
// is taken while it waits.

module bitmap_slot_allocator import bsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bsa_in_if.sink           i_in,
    bsa_out_if.source        o_out
);

    logic [CNT_W-1:0] r_slot_count;
    logic [CNT_W-1:0] cfg_sat;
    t_cfg_wr          cfg;
    t_result          res;
    t_ram_req         ram_req;
    t_word            rd_data;
    logic             res_free;

    logic             r_out_valid;
    t_status          r_status;
    logic [IDX_W-1:0] r_slot;
    logic             r_was_used;
    logic [CNT_W-1:0] r_free;

    // Saturate the slot count at the bitmap size
    assign cfg_sat   = (i_cfg_wdata > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : i_cfg_wdata;
    assign cfg.we    = i_cfg_we;
    assign cfg.count = cfg_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CNT_W'(MAX_SLOTS);
        end else if (i_cfg_we) begin
            r_slot_count <= cfg_sat;
        end
    end

    bsa_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    bsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_slot_count (r_slot_count),
        .i_in         (i_in),
        .i_res_free   (res_free),
        .o_res        (res),
        .o_ram        (ram_req),
        .i_rd_data    (rd_data)
    );

    // Output register: load a new result, drop the old one once taken
    assign res_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_status   <= res.status;
            r_slot     <= res.slot;
            r_was_used <= res.was_used;
            r_free     <= res.free;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.slot_out      = r_slot;
    assign o_out.slot_was_used = r_was_used;
    assign o_out.free_slots    = r_free;

endmodule

### rtl/core/bsa_ram.sv
// Bitmap word memory: one write and one registered read port per cycle.
// Depends on bsa_pkg for the word type and the request struct.

module bsa_ram import bsa_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_word    o_rd_data
);

    t_word mem [WORD_COUNT];
    t_word r_rd_data;

    // Write the addressed word
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read; hold the data when no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/bsa_ctrl.sv
// Sequencer of the bitmap slot allocator: clearing sweep, next-fit scan and
// read-modify-write of single slots. Depends on bsa_pkg and bsa_if.

module bsa_ctrl import bsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  logic [CNT_W-1:0] i_slot_count,
    bsa_in_if.sink           i_in,
    input  logic             i_res_free,
    output t_result          o_res,
    output t_ram_req         o_ram,
    input  t_word            i_rd_data
);

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state           r_state,   n_state;
    t_op              r_op,      n_op;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic [WA_W-1:0]  r_cur,     n_cur;
    logic [WC_W-1:0]  r_k,       n_k;
    logic [WA_W-1:0]  r_search,  n_search;
    logic [CNT_W-1:0] r_used,    n_used;
    logic [CNT_W-1:0] r_clr_n,   n_clr_n;
    logic [WC_W-1:0]  r_sw_idx,  n_sw_idx;
    logic             r_sw_pend, n_sw_pend;
    logic [WA_W-1:0]  r_sw_wa,   n_sw_wa;

    logic [WC_W-1:0]  nw;
    logic [WC_W-1:0]  cur_next;
    t_word            avail;
    t_word            masked;
    logic [BIT_W-1:0] free_bit;
    logic [BIT_W-1:0] idx_bit;
    logic             was;
    logic             in_fire;

    assign nw       = words_in_use(i_slot_count);
    assign cur_next = {1'b0, r_cur} + WC_W'(1);
    assign avail    = valid_bits(r_cur, i_slot_count) & ~i_rd_data;
    assign free_bit = lowest_bit(avail);
    assign masked   = i_rd_data & valid_bits(r_sw_wa, r_clr_n);
    assign idx_bit  = r_idx[BIT_W-1:0];
    assign was      = i_rd_data[idx_bit];

    assign i_in.ready = (r_state == S_IDLE) && !i_cfg.we;
    assign in_fire    = i_in.valid && i_in.ready;

    // Next state, memory requests and result
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_cur     = r_cur;
        n_k       = r_k;
        n_search  = r_search;
        n_used    = r_used;
        n_clr_n   = r_clr_n;
        n_sw_idx  = r_sw_idx;
        n_sw_pend = r_sw_pend;
        n_sw_wa   = r_sw_wa;
        o_ram     = '0;
        o_res     = '0;
        o_res.status = ST_OK;

        unique case (r_state)
            S_SWEEP: begin
                // Write back the masked word read in the last cycle
                if (r_sw_pend) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_sw_wa;
                    o_ram.wr_data = masked;
                    n_used        = r_used + CNT_W'(pop_count(masked));
                end
                // Advance the read side of the sweep
                if (r_sw_idx < WC_W'(WORD_COUNT)) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_sw_idx[WA_W-1:0];
                    n_sw_idx      = r_sw_idx + WC_W'(1);
                    n_sw_pend     = 1'b1;
                    n_sw_wa       = r_sw_idx[WA_W-1:0];
                end else begin
                    n_sw_pend = 1'b0;
                    if (!r_sw_pend) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op  = t_op'(i_in.operation);
                    n_idx = i_in.slot_index;
                    o_ram.rd_en = 1'b1;
                    if (t_op'(i_in.operation) == OP_ALLOC) begin
                        o_ram.rd_addr = r_search;
                        n_cur   = r_search;
                        n_k     = '0;
                        n_state = S_SCAN;
                    end else begin
                        o_ram.rd_addr = WA_W'(i_in.slot_index >> BIT_W);
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (i_res_free) begin
                    if (r_k >= nw) begin
                        // Every word in use examined: report no free slot
                        o_res.valid  = 1'b1;
                        o_res.status = ST_NO_FREE;
                        o_res.free   = i_slot_count - r_used;
                        n_state      = S_IDLE;
                    end else if (|avail) begin
                        // Take the lowest free bit and remember the word
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_addr = r_cur;
                        o_ram.wr_data = i_rd_data | (t_word'(1) << free_bit);
                        n_search      = r_cur;
                        n_used        = r_used + CNT_W'(1);
                        o_res.valid   = 1'b1;
                        o_res.slot    = IDX_W'({r_cur, free_bit});
                        o_res.free    = i_slot_count - n_used;
                        n_state       = S_IDLE;
                    end else begin
                        // Move on to the next word, wrapping at the last one in use
                        o_ram.rd_en = 1'b1;
                        if (cur_next == nw) begin
                            n_cur = '0;
                        end else begin
                            n_cur = cur_next[WA_W-1:0];
                        end
                        o_ram.rd_addr = n_cur;
                        n_k = r_k + WC_W'(1);
                    end
                end
            end
            S_EXEC: begin
                if (i_res_free) begin
                    o_res.valid = 1'b1;
                    o_res.slot  = r_idx;
                    n_state     = S_IDLE;
                    if ({1'b0, r_idx} >= i_slot_count) begin
                        o_res.status = ST_RANGE;
                    end else begin
                        o_res.was_used = was;
                        unique case (r_op)
                            OP_CLAIM: begin
                                if (was) begin
                                    o_res.status = ST_USED;
                                end else begin
                                    o_ram.wr_en   = 1'b1;
                                    o_ram.wr_addr = WA_W'(r_idx >> BIT_W);
                                    o_ram.wr_data = i_rd_data | (t_word'(1) << idx_bit);
                                    n_used        = r_used + CNT_W'(1);
                                end
                            end
                            OP_RELEASE: begin
                                o_ram.wr_en   = 1'b1;
                                o_ram.wr_addr = WA_W'(r_idx >> BIT_W);
                                o_ram.wr_data = i_rd_data & ~(t_word'(1) << idx_bit);
                                if (was) begin
                                    n_used = r_used - CNT_W'(1);
                                end
                            end
                            OP_ALLOC, OP_TEST: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                    o_res.free = i_slot_count - n_used;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase

        // Slot count write: restart the clearing sweep with the tightest limit
        if (i_cfg.we) begin
            n_state   = S_SWEEP;
            n_sw_idx  = '0;
            n_sw_pend = 1'b0;
            n_used    = '0;
            if (r_state == S_SWEEP && i_cfg.count > r_clr_n) begin
                n_clr_n = r_clr_n;
            end else begin
                n_clr_n = i_cfg.count;
            end
            if ({1'b0, r_search} >= words_in_use(i_cfg.count)) begin
                n_search = '0;
            end
        end
    end

    // Control registers; reset starts a sweep that clears every word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_search  <= '0;
            r_used    <= '0;
            r_clr_n   <= '0;
            r_sw_idx  <= '0;
            r_sw_pend <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_search  <= n_search;
            r_used    <= n_used;
            r_clr_n   <= n_clr_n;
            r_sw_idx  <= n_sw_idx;
            r_sw_pend <= n_sw_pend;
            r_k       <= n_k;
        end
    end

    // Transaction payload and scan position
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_sw_wa <= n_sw_wa;
    end

endmodule
